@@ hw/rtl/bhtdr_pkg.sv @@
// ----------------------------------------------------------------------------
// bhtdr_pkg: shared types and constants of the bucketed hash table
// Entry, item and result layouts, configuration register codes and defaults.
// ----------------------------------------------------------------------------
package bhtdr_pkg;

	// Default geometry: bucket count is a power of two.
	localparam int DEF_BUCKET_COUNT = 1024;
	localparam int DEF_WAYS         = 4;

	// Rank and replacement limit need one bit above the stored depth.
	localparam int RANK_W = 9;

	// Depth allowance granted to an exact bound when it overwrites its own key.
	localparam int EXACT_BONUS = 2;

	// Actions carried on the input word.
	localparam logic ACT_PROBE = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_MATE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXACT_CODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OLD_MASK       = 2'd2;

	// Register values after reset.
	localparam logic [14:0] RST_MATE_THRESHOLD = 15'd30000;
	localparam logic [3:0]  RST_EXACT_CODE     = 4'd1;
	localparam logic [3:0]  RST_OLD_MASK       = 4'd4;

	// One table entry as held in a bucket row.
	typedef struct packed {
		logic               valid;
		logic [63:0]        key;
		logic signed [15:0] score;
		logic signed [15:0] eval;
		logic [7:0]         depth;
		logic [3:0]         flags;
		logic [15:0]        move;
	} entry_t;

	// Registered input word, score already mate adjusted.
	typedef struct packed {
		logic               action;
		logic [63:0]        key;
		logic signed [15:0] score;
		logic signed [15:0] eval;
		logic [7:0]         depth;
		logic [3:0]         flags;
		logic [15:0]        move;
	} item_t;

	// Result word.
	typedef struct packed {
		logic               found;
		logic signed [15:0] score;
		logic signed [15:0] eval;
		logic [7:0]         depth;
		logic [3:0]         flags;
		logic [15:0]        move;
	} result_t;

	// Configuration seen by the update logic.
	typedef struct packed {
		logic [3:0] exact_code;
		logic [3:0] old_mask;
	} cfg_t;

endpackage

@@ hw/rtl/bhtdr_bucket_ram.sv @@
// ----------------------------------------------------------------------------
// bhtdr_bucket_ram: bucket row memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bhtdr_bucket_ram #(
	parameter int DEPTH = 1024,
	parameter int DATA_W = 500,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/bhtdr_bucket_update.sv @@
// ----------------------------------------------------------------------------
// bhtdr_bucket_update: bucket modify logic
// Matches the key across the ways, then builds the written-back row and the
// result word for a probe, an in-place update or a ranked insertion.
// ----------------------------------------------------------------------------
module bhtdr_bucket_update #(
	parameter int WAYS = 4
) (
	input  bhtdr_pkg::cfg_t               cfg,
	input  bhtdr_pkg::item_t              item,
	input  bhtdr_pkg::entry_t [WAYS-1:0]  row_in,
	output bhtdr_pkg::entry_t [WAYS-1:0]  row_out,
	output bhtdr_pkg::result_t            result
);
	import bhtdr_pkg::*;

	logic [WAYS-1:0]   hit;
	logic [WAYS-1:0]   first_hit;
	logic [WAYS-1:0]   rank_le;
	logic [WAYS:0]     keep_run;
	logic [WAYS-1:0]   shift_in;
	logic              hit_any;
	logic [RANK_W-1:0] new_rank;
	logic [RANK_W-1:0] limit;
	logic [RANK_W-1:0] way_rank [WAYS];
	entry_t [WAYS-1:0] row_shift;
	entry_t            new_entry;

	// Key match, ranks and the replacement limit.
	always_comb begin
		logic seen;
		seen = 1'b0;
		new_rank = {1'b0, item.depth} + RANK_W'(|(item.flags & cfg.exact_code));
		limit = {1'b0, item.depth} +
			((item.flags == cfg.exact_code) ? RANK_W'(EXACT_BONUS) : RANK_W'(0));
		for (int w = 0; w < WAYS; w++) begin
			hit[w] = row_in[w].valid && (row_in[w].key == item.key);
			first_hit[w] = hit[w] && !seen;
			seen = seen | hit[w];
			way_rank[w] = row_in[w].valid ?
				({1'b0, row_in[w].depth} + RANK_W'(|(row_in[w].flags & cfg.exact_code))) :
				RANK_W'(0);
			rank_le[w] = (way_rank[w] <= new_rank);
		end
		hit_any = seen;
	end

	// Run of ways from the bottom of the bucket that rank no higher than the
	// new entry; the new entry lands at the top of that run.
	always_comb begin
		keep_run[WAYS] = 1'b1;
		for (int w = WAYS - 1; w >= 0; w--) begin
			keep_run[w] = rank_le[w] & keep_run[w+1];
		end
	end

	assign shift_in  = {keep_run[WAYS-2:0], 1'b0};
	assign row_shift = {row_in[WAYS-2:0], entry_t'('0)};

	always_comb begin
		new_entry       = '0;
		new_entry.valid = 1'b1;
		new_entry.key   = item.key;
		new_entry.score = item.score;
		new_entry.eval  = item.eval;
		new_entry.depth = item.depth;
		new_entry.flags = item.flags;
		new_entry.move  = item.move;
	end

	// Row to write back and the result word.
	always_comb begin
		row_out = row_in;
		result = '0;
		result.found = hit_any;
		for (int w = 0; w < WAYS; w++) begin
			if (item.action == ACT_PROBE) begin
				if (first_hit[w]) begin
					row_out[w].flags = row_in[w].flags & ~cfg.old_mask;
					result.score = row_in[w].score;
					result.eval  = row_in[w].eval;
					result.depth = row_in[w].depth;
					result.flags = row_in[w].flags & ~cfg.old_mask;
					result.move  = row_in[w].move;
				end
			end else if (hit_any) begin
				if (first_hit[w] && ({1'b0, row_in[w].depth} <= limit)) begin
					row_out[w].score = item.score;
					row_out[w].eval  = item.eval;
					row_out[w].depth = item.depth;
					row_out[w].flags = item.flags;
					row_out[w].move  = item.move;
				end
			end else begin
				if (shift_in[w]) begin
					row_out[w] = row_shift[w];
				end else if (keep_run[w]) begin
					row_out[w] = new_entry;
				end
			end
		end
	end

endmodule

@@ hw/rtl/bucketed_hash_table_depth_replace_core.sv @@
// ----------------------------------------------------------------------------
// bucketed_hash_table_depth_replace_core: set-associative position table
// Probes and depth-preferred writes on buckets held in one row memory.
// ----------------------------------------------------------------------------
// Usage.
// Input channel in_valid/in_stall carries one word: action (probe or write),
// key and the entry fields. The low key bits select a bucket row.
// Output channel out_valid/out_stall returns one result word per input word:
// found, and the entry fields on a probe hit (zero otherwise).
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing: a word is accepted and its bucket row is read at that edge; in the
// busy state that follows, the row is modified, written back and loaded into
// the output register. in_stall stays high meanwhile, so a new word is taken
// only after the previous bucket row has been written back.
// The output register lets a new word be accepted while a result waits; a
// finished word waits in the busy state only while out_stall holds a
// previous result.
// After reset the block clears every bucket row, one per cycle, with
// in_stall high; configuration writes still apply.
// ----------------------------------------------------------------------------
module bucketed_hash_table_depth_replace_core #(
	parameter int BUCKET_COUNT = bhtdr_pkg::DEF_BUCKET_COUNT,
	parameter int WAYS = bhtdr_pkg::DEF_WAYS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port
	input  logic                                cfg_we,
	input  logic [bhtdr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bhtdr_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [63:0]                         key,
	input  logic signed [15:0]                  score,
	input  logic signed [15:0]                  static_eval,
	input  logic [7:0]                          search_depth,
	input  logic [3:0]                          bound_flags,
	input  logic [15:0]                         packed_move,
	input  logic [7:0]                          ply,
	// Output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic signed [15:0]                  entry_score,
	output logic signed [15:0]                  entry_eval,
	output logic [7:0]                          entry_depth,
	output logic [3:0]                          entry_flags,
	output logic [15:0]                         entry_move
);
	import bhtdr_pkg::*;

	localparam int IDX_W = $clog2(BUCKET_COUNT);
	localparam int ROW_W = WAYS * $bits(entry_t);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [14:0]       mate_threshold_q;
	logic [3:0]        exact_code_q;
	logic [3:0]        old_mask_q;
	item_t             item_s1;
	logic              out_valid_q;
	result_t           result_q;

	logic              in_accept;
	logic              fire;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  ram_rdata;
	entry_t [WAYS-1:0] row_rd;
	entry_t [WAYS-1:0] row_wr;
	result_t           result_d;
	cfg_t              cfg;

	// Push scores beyond the mate threshold one unit per ply outward, saturating.
	function automatic logic signed [15:0] mate_adjust(
		input logic signed [15:0] s,
		input logic [14:0]        thr,
		input logic [7:0]         p
	);
		logic signed [17:0] v;
		logic signed [17:0] t;
		logic signed [17:0] d;
		v = 18'(s);
		t = 18'(signed'({1'b0, thr}));
		d = 18'(signed'({1'b0, p}));
		if (v < -t) begin
			v = v - d;
		end else if (v > t) begin
			v = v + d;
		end
		if (v > 18'sd32767) begin
			v = 18'sd32767;
		end else if (v < -18'sd32768) begin
			v = -18'sd32768;
		end
		return v[15:0];
	endfunction

	// Handshakes.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign fire      = (state_q == ST_BUSY) && (!out_valid_q || !out_stall);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_threshold_q <= RST_MATE_THRESHOLD;
			exact_code_q     <= RST_EXACT_CODE;
			old_mask_q       <= RST_OLD_MASK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MATE_THRESHOLD: mate_threshold_q <= cfg_data;
				CFG_EXACT_CODE:     exact_code_q     <= cfg_data[3:0];
				CFG_OLD_MASK:       old_mask_q       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg.exact_code = exact_code_q;
	assign cfg.old_mask   = old_mask_q;

	// Capture the accepted word alongside the bucket read.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.action <= action;
			item_s1.key    <= key;
			item_s1.score  <= mate_adjust(score, mate_threshold_q, ply);
			item_s1.eval   <= static_eval;
			item_s1.depth  <= search_depth;
			item_s1.flags  <= bound_flags;
			item_s1.move   <= packed_move;
		end
	end

	// Bucket row memory: the clearing sweep writes zero rows, then each word
	// writes its modified row back.
	assign ram_we    = (state_q == ST_CLEAR) || fire;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : item_s1.key[IDX_W-1:0];
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : row_wr;
	assign row_rd    = ram_rdata;

	bhtdr_bucket_ram #(
		.DEPTH  (BUCKET_COUNT),
		.DATA_W (ROW_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (key[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	bhtdr_bucket_update #(
		.WAYS (WAYS)
	) u_update (
		.cfg     (cfg),
		.item    (item_s1),
		.row_in  (row_rd),
		.row_out (row_wr),
		.result  (result_d)
	);

	// Sequencer, clearing counter and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(BUCKET_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
				result_q    <= result_d;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = result_q.found;
	assign entry_score = result_q.score;
	assign entry_eval  = result_q.eval;
	assign entry_depth = result_q.depth;
	assign entry_flags = result_q.flags;
	assign entry_move  = result_q.move;

endmodule

@@ tb/sv/bucketed_hash_table_depth_replace_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bucketed_hash_table_depth_replace_core_tb: self-checking bench of the table
// A directed table of probes and writes is walked first, then six random
// phases under different register settings. Every accepted word is applied
// to a bench-side copy of the buckets, and each result word is compared field
// by field with the oldest result still due. Both channels idle at random.
// ----------------------------------------------------------------------------
module bucketed_hash_table_depth_replace_core_tb;
	import bhtdr_pkg::*;

	localparam int BUCKETS      = DEF_BUCKET_COUNT;
	localparam int NWAYS        = DEF_WAYS;
	localparam int IDX_W        = $clog2(BUCKETS);
	localparam int QUIET_LIMIT  = 6000;
	localparam int PHASE_WORDS  = 320;
	localparam int NUM_PHASES   = 6;
	localparam int POOL_BUCKETS = 8;
	localparam int POOL_TAGS    = 6;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam result_t NO_HIT   = '0;
	localparam result_t KEY_SEEN = {1'b1, 60'd0};

	// Keys of the directed part, all in bucket five.
	localparam logic [63:0] KEY_A = 64'hFFFF_FFFF_FFFF_FC05;
	localparam logic [63:0] KEY_B = 64'h0000_0000_0000_0405;
	localparam logic [63:0] KEY_C = 64'h1234_5678_9ABC_DC05;
	localparam logic [63:0] KEY_D = 64'h8000_0000_0000_0005;
	localparam logic [63:0] KEY_E = 64'h0000_0001_0000_0005;
	localparam logic [63:0] KEY_F = 64'hDEAD_BEEF_0000_0805;

	// One input word, with an optional result typed in by hand.
	typedef struct {
		logic               action;
		logic [63:0]        key;
		logic signed [15:0] score;
		logic signed [15:0] eval;
		logic [7:0]         depth;
		logic [3:0]         flags;
		logic [15:0]        move;
		logic [7:0]         ply;
		bit                 typed;
		result_t            want;
	} access_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   action = ACT_PROBE;
	logic [63:0]            key = '0;
	logic signed [15:0]     score = '0;
	logic signed [15:0]     static_eval = '0;
	logic [7:0]             search_depth = '0;
	logic [3:0]             bound_flags = '0;
	logic [15:0]            packed_move = '0;
	logic [7:0]             ply = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   found;
	logic signed [15:0]     entry_score;
	logic signed [15:0]     entry_eval;
	logic [7:0]             entry_depth;
	logic [3:0]             entry_flags;
	logic [15:0]            entry_move;

	// Bench copy of the table and of the registers.
	entry_t                 bucket_rows [BUCKETS][NWAYS];
	logic [14:0]            mate_thr = RST_MATE_THRESHOLD;
	logic [3:0]             exact_bits = RST_EXACT_CODE;
	logic [3:0]             old_bits = RST_OLD_MASK;

	logic [63:0]            key_pool [POOL_BUCKETS][POOL_TAGS];
	access_t                directed_tab [$];
	access_t                words_to_send [$];
	result_t                results_due [$];
	access_t                shown_word;
	result_t                applied;
	result_t                oldest;
	int                     send_gap = 0;
	int                     send_calm = 0;
	int                     stall_left = 0;
	int                     recv_calm = 0;
	int                     mismatches = 0;

	bucketed_hash_table_depth_replace_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.key          (key),
		.score        (score),
		.static_eval  (static_eval),
		.search_depth (search_depth),
		.bound_flags  (bound_flags),
		.packed_move  (packed_move),
		.ply          (ply),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.entry_score  (entry_score),
		.entry_eval   (entry_eval),
		.entry_depth  (entry_depth),
		.entry_flags  (entry_flags),
		.entry_move   (entry_move)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Rank used to order a bucket: depth, plus one when an exact bit is set.
	function automatic int rank_of(entry_t e);
		if (!e.valid) begin
			return 0;
		end
		return int'(e.depth) + (((e.flags & exact_bits) != 4'd0) ? 1 : 0);
	endfunction

	// Applies one word to the bench table and returns the result it gives.
	function automatic result_t apply_access(access_t a);
		result_t r;
		entry_t  fresh;
		int      bi, sc, t, lim, nr, i, j;
		r = NO_HIT;
		bi = int'(a.key[IDX_W-1:0]);
		if (a.action == ACT_PROBE) begin
			for (i = 0; i < NWAYS; i++) begin
				if (bucket_rows[bi][i].valid && bucket_rows[bi][i].key == a.key) begin
					bucket_rows[bi][i].flags = bucket_rows[bi][i].flags & ~old_bits;
					r.found = 1'b1;
					r.score = bucket_rows[bi][i].score;
					r.eval  = bucket_rows[bi][i].eval;
					r.depth = bucket_rows[bi][i].depth;
					r.flags = bucket_rows[bi][i].flags;
					r.move  = bucket_rows[bi][i].move;
					return r;
				end
			end
			return r;
		end
		// Mate scores move one step outward per ply, saturating at 16 bits.
		sc = int'(a.score);
		t = int'(mate_thr);
		if (sc < -t) begin
			sc = sc - int'(a.ply);
		end
		if (sc > t) begin
			sc = sc + int'(a.ply);
		end
		if (sc > 32767) begin
			sc = 32767;
		end else if (sc < -32768) begin
			sc = -32768;
		end
		fresh.valid = 1'b1;
		fresh.key   = a.key;
		fresh.score = sc[15:0];
		fresh.eval  = a.eval;
		fresh.depth = a.depth;
		fresh.flags = a.flags;
		fresh.move  = a.move;
		// Same key: overwrite only when the stored depth is not too deep.
		for (i = 0; i < NWAYS; i++) begin
			if (bucket_rows[bi][i].valid && bucket_rows[bi][i].key == a.key) begin
				lim = int'(a.depth) + ((a.flags == exact_bits) ? EXACT_BONUS : 0);
				r.found = 1'b1;
				if (int'(bucket_rows[bi][i].depth) <= lim) begin
					bucket_rows[bi][i] = fresh;
				end
				return r;
			end
		end
		// New key: sorted insertion, the lowest entry falls out.
		nr = rank_of(fresh);
		i = NWAYS;
		while (i > 0 && rank_of(bucket_rows[bi][i-1]) <= nr) begin
			i--;
		end
		if (i < NWAYS) begin
			for (j = NWAYS - 1; j > i; j--) begin
				bucket_rows[bi][j] = bucket_rows[bi][j-1];
			end
			bucket_rows[bi][i] = fresh;
		end
		return r;
	endfunction

	function automatic access_t row(logic act, logic [63:0] k, logic signed [15:0] sc,
			logic signed [15:0] ev, logic [7:0] dp, logic [3:0] fl, logic [15:0] mv,
			logic [7:0] pl, bit ty, result_t w);
		access_t a;
		a.action = act;
		a.key    = k;
		a.score  = sc;
		a.eval   = ev;
		a.depth  = dp;
		a.flags  = fl;
		a.move   = mv;
		a.ply    = pl;
		a.typed  = ty;
		a.want   = w;
		return a;
	endfunction

	// Random word: mostly keys from a small pool so buckets fill and collide.
	function automatic access_t rand_access();
		access_t a;
		int      roll, base;
		a.typed = 1'b0;
		a.want = NO_HIT;
		a.action = ($urandom_range(0, 99) < 55) ? ACT_WRITE : ACT_PROBE;
		if ($urandom_range(0, 99) < 85) begin
			a.key = key_pool[$urandom_range(0, POOL_BUCKETS - 1)][$urandom_range(0, POOL_TAGS - 1)];
		end else begin
			a.key = {$urandom, $urandom};
		end
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			// Scores around the mate threshold, of either sign.
			base = int'(mate_thr) + int'($urandom_range(0, 6)) - 3;
			if (base > 32767) begin
				base = 32767;
			end else if (base < 0) begin
				base = 0;
			end
			if ($urandom_range(0, 1) == 0) begin
				base = -base;
			end
			a.score = base[15:0];
		end else if (roll < 55) begin
			a.score = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
		end else begin
			a.score = 16'($urandom);
		end
		a.eval = 16'($urandom);
		a.depth = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 12)) : 8'($urandom);
		a.flags = ($urandom_range(0, 99) < 35) ? exact_bits : 4'($urandom);
		a.move = 16'($urandom);
		a.ply = 8'($urandom);
		return a;
	endfunction

	// Idle length for either side: mostly short, a few long, some calm runs.
	function automatic int pick_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 50) begin
			return 0;
		end
		if (roll < 88) begin
			return $urandom_range(1, 3);
		end
		if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 50);
	endfunction

	task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t: result word mismatch on %s: expected %0h, got %0h",
			$realtime, field, want, got);
		mismatches++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_MATE_THRESHOLD: mate_thr = value;
			CFG_EXACT_CODE:     exact_bits = value[3:0];
			CFG_OLD_MASK:       old_bits = value[3:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Holds the sender until every result has come back, then a short pause.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (words_to_send.size() != 0 || in_valid || results_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Sender: a word leaves at an edge with valid high and stall low.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			applied = apply_access(shown_word);
			results_due.push_back(shown_word.typed ? shown_word.want : applied);
		end
		if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (words_to_send.size() != 0) begin
				shown_word = words_to_send.pop_front();
				in_valid <= 1'b1;
				action <= shown_word.action;
				key <= shown_word.key;
				score <= shown_word.score;
				static_eval <= shown_word.eval;
				search_depth <= shown_word.depth;
				bound_flags <= shown_word.flags;
				packed_move <= shown_word.move;
				ply <= shown_word.ply;
				send_gap = pick_gap(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: check each result word, then choose the next stall.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("word with nothing due", 64'd0, 64'(found));
			end else begin
				oldest = results_due.pop_front();
				if (found !== oldest.found) begin
					report_mismatch("found", 64'(oldest.found), 64'(found));
				end
				if (entry_score !== oldest.score) begin
					report_mismatch("entry_score", 64'(oldest.score), 64'(entry_score));
				end
				if (entry_eval !== oldest.eval) begin
					report_mismatch("entry_eval", 64'(oldest.eval), 64'(entry_eval));
				end
				if (entry_depth !== oldest.depth) begin
					report_mismatch("entry_depth", 64'(oldest.depth), 64'(entry_depth));
				end
				if (entry_flags !== oldest.flags) begin
					report_mismatch("entry_flags", 64'(oldest.flags), 64'(entry_flags));
				end
				if (entry_move !== oldest.move) begin
					report_mismatch("entry_move", 64'(oldest.move), 64'(entry_move));
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = pick_gap(recv_calm);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run after too many cycles with no word moving.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : main_flow
		int               b, t, p, n;
		logic [IDX_W-1:0] home;
		logic [63:0]      tag;
		logic [14:0]      thr;
		logic [3:0]       ec, om;

		for (b = 0; b < BUCKETS; b++) begin
			for (t = 0; t < NWAYS; t++) begin
				bucket_rows[b][t] = '0;
			end
		end

		// Key pool: both end buckets, bucket five and random ones.
		for (b = 0; b < POOL_BUCKETS; b++) begin
			if (b == 0) begin
				home = '0;
			end else if (b == 1) begin
				home = '1;
			end else if (b == 2) begin
				home = IDX_W'(5);
			end else begin
				home = IDX_W'($urandom_range(0, BUCKETS - 1));
			end
			for (t = 0; t < POOL_TAGS; t++) begin
				tag = {$urandom, $urandom};
				key_pool[b][t] = {tag[63:IDX_W], home};
			end
		end
		// Key zero and the all-ones key are written and probed as well.
		key_pool[0][0] = '0;
		key_pool[1][0] = '1;

		// Directed table under the reset values of the registers.
		// Empty table: key zero and the all-ones key miss.
		directed_tab.push_back(row(ACT_PROBE, 64'd0, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b1, NO_HIT));
		directed_tab.push_back(row(ACT_PROBE, '1, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b1, NO_HIT));
		// Extremes stored, the top score saturates after the mate push.
		directed_tab.push_back(row(ACT_WRITE, KEY_A, 16'sh7FFF, 16'sh8000, 8'd255, 4'd1,
			16'hFFFF, 8'd255, 1'b1, NO_HIT));
		directed_tab.push_back(row(ACT_PROBE, KEY_A, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b1, {1'b1, 16'sh7FFF, 16'sh8000, 8'd255, 4'd1, 16'hFFFF}));
		// Shallower write to the same key leaves the entry alone.
		directed_tab.push_back(row(ACT_WRITE, KEY_A, 16'sh8000, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd255, 1'b1, KEY_SEEN));
		directed_tab.push_back(row(ACT_PROBE, KEY_A, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b1, {1'b1, 16'sh7FFF, 16'sh8000, 8'd255, 4'd1, 16'hFFFF}));
		// Negative mate score with the old bit set; probes clear the old bit.
		directed_tab.push_back(row(ACT_WRITE, KEY_B, -16'sd30001, 16'sd123, 8'd10, 4'd6,
			16'h1234, 8'd10, 1'b1, NO_HIT));
		directed_tab.push_back(row(ACT_PROBE, KEY_B, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b0, NO_HIT));
		directed_tab.push_back(row(ACT_PROBE, KEY_B, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b0, NO_HIT));
		// Score right on the threshold is not moved; equal rank goes above.
		directed_tab.push_back(row(ACT_WRITE, KEY_C, 16'sd30000, -16'sd1, 8'd10, 4'd0,
			16'hABCD, 8'd200, 1'b0, NO_HIT));
		directed_tab.push_back(row(ACT_WRITE, KEY_D, 16'sd30001, 16'sd7, 8'd5, 4'd1,
			16'h0F0F, 8'd1, 1'b0, NO_HIT));
		// Bucket full: a deeper new key shifts the lowest one out.
		directed_tab.push_back(row(ACT_WRITE, KEY_E, 16'sd100, 16'sd9, 8'd7, 4'd8,
			16'h5A5A, 8'd7, 1'b0, NO_HIT));
		directed_tab.push_back(row(ACT_PROBE, KEY_D, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b0, NO_HIT));
		// New entry ranking below the whole bucket is dropped.
		directed_tab.push_back(row(ACT_WRITE, KEY_F, 16'sd1, 16'sd1, 8'd0, 4'd0, 16'd1,
			8'd0, 1'b1, NO_HIT));
		directed_tab.push_back(row(ACT_PROBE, KEY_F, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b1, NO_HIT));
		// Exact bound gets two plies of allowance over the stored depth.
		directed_tab.push_back(row(ACT_WRITE, KEY_A, 16'sd5, 16'sd6, 8'd253, 4'd1,
			16'h0001, 8'd0, 1'b1, KEY_SEEN));
		directed_tab.push_back(row(ACT_PROBE, KEY_A, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b0, NO_HIT));
		directed_tab.push_back(row(ACT_WRITE, KEY_B, 16'sd50, 16'sd50, 8'd9, 4'd0,
			16'h0002, 8'd0, 1'b0, NO_HIT));
		directed_tab.push_back(row(ACT_WRITE, KEY_B, 16'sd60, 16'sd60, 8'd8, 4'd1,
			16'h0003, 8'd0, 1'b0, NO_HIT));
		directed_tab.push_back(row(ACT_PROBE, KEY_B, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b0, NO_HIT));
		// Saturation at both ends, in the last bucket.
		directed_tab.push_back(row(ACT_WRITE, 64'h0000_0000_0000_03FF, 16'sh8000, 16'sh7FFF,
			8'd1, 4'd15, 16'h8000, 8'd1, 1'b0, NO_HIT));
		directed_tab.push_back(row(ACT_PROBE, 64'h0000_0000_0000_03FF, 16'sd0, 16'sd0, 8'd0,
			4'd0, 16'd0, 8'd0, 1'b0, NO_HIT));
		directed_tab.push_back(row(ACT_WRITE, '1, 16'sd32760, 16'sd0, 8'd2, 4'd2, 16'h7FFF,
			8'd200, 1'b0, NO_HIT));
		directed_tab.push_back(row(ACT_PROBE, '1, 16'sd0, 16'sd0, 8'd0, 4'd0, 16'd0,
			8'd0, 1'b0, NO_HIT));

		// Reset, then the block clears its rows before taking words.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		foreach (directed_tab[r]) begin
			words_to_send.push_back(directed_tab[r]);
		end
		wait_drained();

		// Random phases, each under its own register setting.
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin thr = RST_MATE_THRESHOLD; ec = RST_EXACT_CODE; om = RST_OLD_MASK; end
				1: begin thr = 15'd0; ec = 4'd15; om = 4'd15; end
				2: begin thr = 15'h7FFF; ec = 4'd0; om = 4'd0; end
				4: begin thr = 15'd100; ec = 4'd2; om = 4'd8; end
				default: begin
					thr = 15'($urandom);
					ec = 4'($urandom);
					om = 4'($urandom);
				end
			endcase
			// Upper data bits are noise for the four-bit registers.
			write_reg(CFG_MATE_THRESHOLD, thr);
			write_reg(CFG_EXACT_CODE, {11'($urandom), ec});
			write_reg(CFG_OLD_MASK, {11'($urandom), om});
			write_reg(CFG_SPARE, 15'($urandom));
			@(negedge clk);
			for (n = 0; n < PHASE_WORDS; n++) begin
				words_to_send.push_back(rand_access());
			end
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
